>>> hdl/codon_usage_counter_defines.svh
// Assertion macros for the checker file of the codon usage counter.
`ifndef CODON_USAGE_COUNTER_DEFINES_SVH
`define CODON_USAGE_COUNTER_DEFINES_SVH

// Concurrent assertion that is switched off while reset is high.
`define CUC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define CUC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/cuc_pkg.sv
// Shared types, constants, lookup tables and helper functions of the codon usage counter.
`default_nettype none

package cuc_pkg;

   localparam int COUNT_BITS      = 20;
   localparam int FIELD_BITS      = 20;
   localparam int WIDE_BITS       = (COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS;
   localparam int NUM_CODONS      = 64;
   localparam int NUM_AMINOS      = 22;
   localparam int CODON_ADDR_BITS = $clog2(NUM_CODONS);
   localparam int AMINO_ADDR_BITS = $clog2(NUM_AMINOS);
   localparam int CMD_BITS        = 3;
   localparam int CHAR_BITS       = 8;
   localparam int INDEX_BITS      = 6;
   localparam int KIND_BITS       = 2;
   localparam int CODON_BITS      = 7;
   localparam int AMINO_BITS      = 5;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);

   localparam logic [CODON_BITS-1:0] NO_CODON  = 7'd64;
   localparam logic [FIELD_BITS-1:0] FIELD_MAX = {FIELD_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [CMD_BITS-1:0] {
      CMD_CLEAR      = 3'd0,
      CMD_BASE       = 3'd1,
      CMD_READ_CODON = 3'd2,
      CMD_READ_AMINO = 3'd3,
      CMD_END        = 3'd4
   } cmd_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_CODON = 2'd0,
      KIND_COUNT = 2'd1,
      KIND_END   = 2'd2
   } kind_type;

   // Work handed from the front to the back.
   typedef enum logic [2:0] {
      OP_CLEAR      = 3'd0,
      OP_BUMP       = 3'd1,
      OP_READ_CODON = 3'd2,
      OP_READ_AMINO = 3'd3,
      OP_REPORT     = 3'd4
   } op_type;

   typedef struct packed {
      op_type                  op;
      kind_type                kind;
      logic [CODON_BITS-1:0]   codon_index;
      logic [AMINO_BITS-1:0]   amino_index;
      logic [FIELD_BITS-1:0]   position;
      logic                    all_recognized;
   } work_type;

   // Base code (A0 C1 G2 T3, first base most significant) to codon index.
   localparam logic [CODON_ADDR_BITS-1:0] CODE_TO_CODON [NUM_CODONS] = '{
      6'd21, 6'd30, 6'd22, 6'd31, 6'd48, 6'd49, 6'd50, 6'd51,
      6'd38, 6'd59, 6'd39, 6'd60, 6'd18, 6'd19, 6'd29, 6'd20,
      6'd36, 6'd16, 6'd37, 6'd17, 6'd32, 6'd33, 6'd34, 6'd35,
      6'd40, 6'd41, 6'd42, 6'd43, 6'd23, 6'd24, 6'd25, 6'd26,
      6'd8,  6'd6,  6'd9,  6'd7,  6'd0,  6'd1,  6'd2,  6'd3,
      6'd12, 6'd13, 6'd14, 6'd15, 6'd52, 6'd53, 6'd54, 6'd55,
      6'd61, 6'd57, 6'd62, 6'd58, 6'd44, 6'd45, 6'd46, 6'd47,
      6'd63, 6'd4,  6'd56, 6'd5,  6'd27, 6'd10, 6'd28, 6'd11
   };

   // Codon index to amino index under the standard genetic code.
   localparam logic [AMINO_BITS-1:0] CODON_TO_AMINO [NUM_CODONS] = '{
      5'd0,  5'd0,  5'd0,  5'd0,  5'd1,  5'd1,  5'd2,  5'd2,
      5'd3,  5'd3,  5'd4,  5'd4,  5'd5,  5'd5,  5'd5,  5'd5,
      5'd6,  5'd6,  5'd7,  5'd7,  5'd7,  5'd8,  5'd8,  5'd9,
      5'd9,  5'd9,  5'd9,  5'd9,  5'd9,  5'd10, 5'd11, 5'd11,
      5'd12, 5'd12, 5'd12, 5'd12, 5'd13, 5'd13, 5'd14, 5'd14,
      5'd14, 5'd14, 5'd14, 5'd14, 5'd15, 5'd15, 5'd15, 5'd15,
      5'd16, 5'd16, 5'd16, 5'd16, 5'd17, 5'd17, 5'd17, 5'd17,
      5'd18, 5'd19, 5'd19, 5'd20, 5'd20, 5'd21, 5'd21, 5'd21
   };

   function automatic logic [CHAR_BITS-1:0] upcase(input logic [CHAR_BITS-1:0] ch);
      logic [CHAR_BITS-1:0] res;
      res = ch;
      if (ch >= 8'h61 && ch <= 8'h7A) begin
         res = ch - 8'h20;
      end
      return res;
   endfunction

   // Bit 2 set means the character is not one of A, C, G, T.
   function automatic logic [2:0] base_code(input logic [CHAR_BITS-1:0] ch);
      logic [2:0] res;
      unique case (ch)
         8'h41:   res = 3'd0;
         8'h43:   res = 3'd1;
         8'h47:   res = 3'd2;
         8'h54:   res = 3'd3;
         default: res = 3'd4;
      endcase
      return res;
   endfunction

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      logic [COUNT_BITS-1:0] res;
      res = (v == COUNT_MAX) ? v : v + 1'b1;
      return res;
   endfunction

   function automatic logic [FIELD_BITS-1:0] read_sat(input logic [COUNT_BITS-1:0] v);
      logic [WIDE_BITS-1:0]  wide;
      logic [FIELD_BITS-1:0] res;
      wide = WIDE_BITS'(v);
      if (wide > WIDE_BITS'(FIELD_MAX)) begin
         res = FIELD_MAX;
      end else begin
         res = wide[FIELD_BITS-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

>>> hdl/cuc_if.sv
// Valid/ready channel interfaces for the request and response sides.
`default_nettype none

interface cuc_req_if;
   logic                             valid;
   logic                             ready;
   logic [cuc_pkg::CMD_BITS-1:0]     command;
   logic [cuc_pkg::CHAR_BITS-1:0]    char_in;
   logic [cuc_pkg::INDEX_BITS-1:0]   table_index;

   modport source (output valid, command, char_in, table_index, input ready);
   modport sink   (input valid, command, char_in, table_index, output ready);
endinterface

interface cuc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [cuc_pkg::KIND_BITS-1:0]    result_kind;
   logic [cuc_pkg::CODON_BITS-1:0]   codon_index;
   logic [cuc_pkg::AMINO_BITS-1:0]   amino_index;
   logic [cuc_pkg::FIELD_BITS-1:0]   position;
   logic [cuc_pkg::FIELD_BITS-1:0]   count_value;
   logic                             all_recognized;

   modport source (output valid, result_kind, codon_index, amino_index, position,
                   count_value, all_recognized, input ready);
   modport sink   (input valid, result_kind, codon_index, amino_index, position,
                   count_value, all_recognized, output ready);
endinterface

`default_nettype wire

>>> hdl/cuc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cuc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       we,
   input  wire logic [$clog2(DEPTH)-1:0]   waddr,
   input  wire logic [WIDTH-1:0]           wdata,
   input  wire logic                       re,
   input  wire logic [$clog2(DEPTH)-1:0]   raddr,
   output logic      [WIDTH-1:0]           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Read returns the old contents when the same address is written in that cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

>>> hdl/cuc_front.sv
// Front end: accepts requests, tracks the codon framing and classifies the work.
`default_nettype none

module cuc_front (
   input  wire logic           clock,
   input  wire logic           reset,
   cuc_req_if.sink             req_ch,
   input  wire logic           q_full,
   output logic                push,
   output cuc_pkg::work_type   push_data
);

   logic [2*cuc_pkg::CHAR_BITS-1:0]  pend_ff, pend_in;
   logic [1:0]                       phase_ff, phase_in;
   logic [cuc_pkg::FIELD_BITS-1:0]   pos_ff, pos_in;
   logic                             flag_ff, flag_in;
   logic                             accept;
   logic [cuc_pkg::CHAR_BITS-1:0]    ch;
   logic [2:0]                       b0, b1, b2;
   logic                             recog;
   logic [cuc_pkg::CODON_ADDR_BITS-1:0] codon_id;
   logic [cuc_pkg::FIELD_BITS-1:0]   pos_next;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && req_ch.ready;

   assign ch       = cuc_pkg::upcase(req_ch.char_in);
   assign b0       = cuc_pkg::base_code(pend_ff[2*cuc_pkg::CHAR_BITS-1:cuc_pkg::CHAR_BITS]);
   assign b1       = cuc_pkg::base_code(pend_ff[cuc_pkg::CHAR_BITS-1:0]);
   assign b2       = cuc_pkg::base_code(ch);
   assign recog    = !b0[2] && !b1[2] && !b2[2];
   assign codon_id = cuc_pkg::CODE_TO_CODON[{b0[1:0], b1[1:0], b2[1:0]}];
   assign pos_next = (pos_ff == cuc_pkg::FIELD_MAX) ? pos_ff : pos_ff + 1'b1;

   always_comb begin
      pend_in   = pend_ff;
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      flag_in   = flag_ff;
      push      = 1'b0;
      push_data.op             = cuc_pkg::OP_REPORT;
      push_data.kind           = cuc_pkg::KIND_CODON;
      push_data.codon_index    = cuc_pkg::NO_CODON;
      push_data.amino_index    = '0;
      push_data.position       = '0;
      push_data.all_recognized = flag_ff;
      if (accept) begin
         unique case (req_ch.command)
            cuc_pkg::CMD_CLEAR: begin
               push         = 1'b1;
               push_data.op = cuc_pkg::OP_CLEAR;
               pend_in      = '0;
               phase_in     = '0;
               pos_in       = '0;
               flag_in      = 1'b1;
            end
            cuc_pkg::CMD_BASE: begin
               if (phase_ff != 2'd2) begin
                  pend_in  = {pend_ff[cuc_pkg::CHAR_BITS-1:0], ch};
                  phase_in = phase_ff + 1'b1;
               end else begin
                  push               = 1'b1;
                  push_data.position = pos_ff;
                  if (recog) begin
                     push_data.op          = cuc_pkg::OP_BUMP;
                     push_data.codon_index = {1'b0, codon_id};
                     push_data.amino_index = cuc_pkg::CODON_TO_AMINO[codon_id];
                  end else begin
                     flag_in                  = 1'b0;
                     push_data.all_recognized = 1'b0;
                  end
                  pos_in   = pos_next;
                  pend_in  = '0;
                  phase_in = '0;
               end
            end
            cuc_pkg::CMD_READ_CODON: begin
               push                  = 1'b1;
               push_data.op          = cuc_pkg::OP_READ_CODON;
               push_data.kind        = cuc_pkg::KIND_COUNT;
               push_data.codon_index = {1'b0, req_ch.table_index};
               push_data.amino_index = cuc_pkg::CODON_TO_AMINO[req_ch.table_index];
            end
            cuc_pkg::CMD_READ_AMINO: begin
               push           = 1'b1;
               push_data.kind = cuc_pkg::KIND_COUNT;
               // An index past the last amino acid reads as zero, whatever the memory holds.
               if (req_ch.table_index < cuc_pkg::INDEX_BITS'(cuc_pkg::NUM_AMINOS)) begin
                  push_data.op          = cuc_pkg::OP_READ_AMINO;
                  push_data.amino_index = req_ch.table_index[cuc_pkg::AMINO_BITS-1:0];
               end
            end
            cuc_pkg::CMD_END: begin
               push               = 1'b1;
               push_data.kind     = cuc_pkg::KIND_END;
               push_data.position = pos_ff;
               if (phase_ff != 2'd0) begin
                  push_data.all_recognized = 1'b0;
               end else begin
                  push_data.codon_index    = '0;
               end
               pend_in  = '0;
               phase_in = '0;
               pos_in   = '0;
               flag_in  = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         phase_ff <= '0;
         pos_ff   <= '0;
         flag_ff  <= 1'b1;
      end else begin
         pend_ff  <= pend_in;
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         flag_ff  <= flag_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/cuc_queue.sv
// Small FIFO of classified work between the front end and the counter back end.
`default_nettype none

module cuc_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire cuc_pkg::work_type   push_data,
   output logic                     full,
   input  wire logic                pop,
   output cuc_pkg::work_type        head,
   output logic                     not_empty
);

   cuc_pkg::work_type                mem_ff [cuc_pkg::QUEUE_DEPTH];
   logic [cuc_pkg::QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [cuc_pkg::QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [cuc_pkg::QPTR_BITS:0]      cnt_ff, cnt_in;

   assign full      = (cnt_ff == (cuc_pkg::QPTR_BITS+1)'(cuc_pkg::QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/cuc_back.sv
// Back end: codon and amino histograms with read-modify-write, and the response register.
`default_nettype none

module cuc_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cuc_pkg::work_type   head,
   input  wire logic                not_empty,
   output logic                     pop,
   cuc_rsp_if.source                rsp_ch
);

   localparam int CA = cuc_pkg::CODON_ADDR_BITS;
   localparam int AA = cuc_pkg::AMINO_ADDR_BITS;
   localparam int CB = cuc_pkg::COUNT_BITS;
   localparam int FB = cuc_pkg::FIELD_BITS;

   // Stage two holds the operation whose memory read data is now available.
   cuc_pkg::work_type           s2_ff, s2_in;
   logic                        s2_vld_ff, s2_vld_in;
   logic                        s2_adv;
   logic [CA-1:0]               s2_caddr;
   logic [AA-1:0]               s2_aaddr;

   logic [CB-1:0]               cod_rdata, ami_rdata;
   logic [CB-1:0]               cod_val, ami_val;
   logic [CB-1:0]               cod_new, ami_new;
   logic                        bump_we;

   // Per-entry valid bits let a clear take effect without a clearing pass.
   logic [cuc_pkg::NUM_CODONS-1:0] cod_vld_ff, cod_vld_in;
   logic [cuc_pkg::NUM_AMINOS-1:0] ami_vld_ff, ami_vld_in;

   // Most recent write to each memory, forwarded to a read issued in the same cycle.
   logic                        cod_lw_vld_ff, cod_lw_vld_in;
   logic [CA-1:0]               cod_lw_addr_ff;
   logic [CB-1:0]               cod_lw_data_ff;
   logic                        ami_lw_vld_ff, ami_lw_vld_in;
   logic [AA-1:0]               ami_lw_addr_ff;
   logic [CB-1:0]               ami_lw_data_ff;

   logic                        rsp_vld_ff, rsp_vld_in;
   logic                        rsp_load;
   logic [cuc_pkg::KIND_BITS-1:0]  rsp_kind_ff;
   logic [cuc_pkg::CODON_BITS-1:0] rsp_codon_ff;
   logic [cuc_pkg::AMINO_BITS-1:0] rsp_amino_ff;
   logic [FB-1:0]               rsp_pos_ff;
   logic [FB-1:0]               rsp_count_ff, rsp_count_in;
   logic                        rsp_flag_ff;

   assign s2_adv   = s2_vld_ff && (!rsp_vld_ff || rsp_ch.ready);
   assign pop      = not_empty && (!s2_vld_ff || s2_adv);
   assign s2_caddr = s2_ff.codon_index[CA-1:0];
   assign s2_aaddr = s2_ff.amino_index[AA-1:0];
   assign bump_we  = s2_adv && (s2_ff.op == cuc_pkg::OP_BUMP);
   assign rsp_load = s2_adv && (s2_ff.op != cuc_pkg::OP_CLEAR);

   cuc_ram #(.WIDTH(CB), .DEPTH(cuc_pkg::NUM_CODONS)) u_codon_ram (
      .clock (clock),
      .we    (bump_we),
      .waddr (s2_caddr),
      .wdata (cod_new),
      .re    (pop),
      .raddr (head.codon_index[CA-1:0]),
      .rdata (cod_rdata)
   );

   cuc_ram #(.WIDTH(CB), .DEPTH(cuc_pkg::NUM_AMINOS)) u_amino_ram (
      .clock (clock),
      .we    (bump_we),
      .waddr (s2_aaddr),
      .wdata (ami_new),
      .re    (pop),
      .raddr (head.amino_index[AA-1:0]),
      .rdata (ami_rdata)
   );

   always_comb begin
      if (!cod_vld_ff[s2_caddr]) begin
         cod_val = '0;
      end else if (cod_lw_vld_ff && cod_lw_addr_ff == s2_caddr) begin
         cod_val = cod_lw_data_ff;
      end else begin
         cod_val = cod_rdata;
      end
      if (!ami_vld_ff[s2_aaddr]) begin
         ami_val = '0;
      end else if (ami_lw_vld_ff && ami_lw_addr_ff == s2_aaddr) begin
         ami_val = ami_lw_data_ff;
      end else begin
         ami_val = ami_rdata;
      end
      cod_new = cuc_pkg::sat_inc(cod_val);
      ami_new = cuc_pkg::sat_inc(ami_val);
   end

   always_comb begin
      s2_in     = s2_ff;
      s2_vld_in = s2_vld_ff;
      if (pop) begin
         s2_in     = head;
         s2_vld_in = 1'b1;
      end else if (s2_adv) begin
         s2_vld_in = 1'b0;
      end

      cod_vld_in    = cod_vld_ff;
      ami_vld_in    = ami_vld_ff;
      cod_lw_vld_in = cod_lw_vld_ff;
      ami_lw_vld_in = ami_lw_vld_ff;
      if (s2_adv && s2_ff.op == cuc_pkg::OP_CLEAR) begin
         cod_vld_in    = '0;
         ami_vld_in    = '0;
         cod_lw_vld_in = 1'b0;
         ami_lw_vld_in = 1'b0;
      end else if (bump_we) begin
         cod_vld_in[s2_caddr] = 1'b1;
         ami_vld_in[s2_aaddr] = 1'b1;
         cod_lw_vld_in        = 1'b1;
         ami_lw_vld_in        = 1'b1;
      end

      unique case (s2_ff.op)
         cuc_pkg::OP_READ_CODON: rsp_count_in = cuc_pkg::read_sat(cod_val);
         cuc_pkg::OP_READ_AMINO: rsp_count_in = cuc_pkg::read_sat(ami_val);
         default:                rsp_count_in = '0;
      endcase

      rsp_vld_in = rsp_vld_ff;
      if (rsp_load) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s2_ff <= s2_in;
      end
      if (bump_we) begin
         cod_lw_addr_ff <= s2_caddr;
         cod_lw_data_ff <= cod_new;
         ami_lw_addr_ff <= s2_aaddr;
         ami_lw_data_ff <= ami_new;
      end
      if (rsp_load) begin
         rsp_kind_ff  <= s2_ff.kind;
         rsp_codon_ff <= s2_ff.codon_index;
         rsp_amino_ff <= s2_ff.amino_index;
         rsp_pos_ff   <= s2_ff.position;
         rsp_count_ff <= rsp_count_in;
         rsp_flag_ff  <= s2_ff.all_recognized;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff     <= 1'b0;
         cod_vld_ff    <= '0;
         ami_vld_ff    <= '0;
         cod_lw_vld_ff <= 1'b0;
         ami_lw_vld_ff <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         s2_vld_ff     <= s2_vld_in;
         cod_vld_ff    <= cod_vld_in;
         ami_vld_ff    <= ami_vld_in;
         cod_lw_vld_ff <= cod_lw_vld_in;
         ami_lw_vld_ff <= ami_lw_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
   end

   assign rsp_ch.valid          = rsp_vld_ff;
   assign rsp_ch.result_kind    = rsp_kind_ff;
   assign rsp_ch.codon_index    = rsp_codon_ff;
   assign rsp_ch.amino_index    = rsp_amino_ff;
   assign rsp_ch.position       = rsp_pos_ff;
   assign rsp_ch.count_value    = rsp_count_ff;
   assign rsp_ch.all_recognized = rsp_flag_ff;

endmodule

`default_nettype wire

>>> hdl/codon_usage_counter.sv
// Codon usage counter: top level joining the front end, the work queue and the counter back end.
// The block takes one request per cycle while the queue is not full: nucleotide characters,
// count reads, end-of-sequence and clear commands. Every third character closes a codon and
// returns a codon report; a recognized codon also bumps a 64-entry codon histogram and a
// 22-entry amino-acid histogram (saturating). Reads and end commands return one response each,
// clear and unused commands none. The sustained rate is one request per cycle while responses
// are taken; a response passes through the queue, stage two and the response register. The
// counter memories are updated by a read-modify-write loop of a memory read followed by an
// increment, and back-to-back updates of the same entry are served by forwarding the latest
// write. A four-entry queue between front and back keeps requests flowing while a response
// waits to be taken. Clear takes effect through per-entry valid bits, with no clearing pass.
`default_nettype none

module codon_usage_counter (
   input  wire logic   clock,
   input  wire logic   reset,
   cuc_req_if.sink     req_ch,
   cuc_rsp_if.source   rsp_ch
);

   logic                q_full;
   logic                q_push;
   logic                q_pop;
   logic                q_not_empty;
   cuc_pkg::work_type   q_push_data;
   cuc_pkg::work_type   q_head;

   cuc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .q_full    (q_full),
      .push      (q_push),
      .push_data (q_push_data)
   );

   cuc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .not_empty (q_not_empty)
   );

   cuc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .not_empty (q_not_empty),
      .pop       (q_pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

>>> hdl/cuc_checker.sv
// Port-level checker for the codon usage counter and its bind to the top level.
`default_nettype none
`include "codon_usage_counter_defines.svh"

module cuc_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [cuc_pkg::KIND_BITS-1:0]    result_kind,
   input wire logic [cuc_pkg::CODON_BITS-1:0]   codon_index,
   input wire logic [cuc_pkg::AMINO_BITS-1:0]   amino_index,
   input wire logic [cuc_pkg::FIELD_BITS-1:0]   position,
   input wire logic [cuc_pkg::FIELD_BITS-1:0]   count_value,
   input wire logic                             all_recognized
);

   `CUC_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, reset |=> !rsp_valid,
      "response valid right after reset")
   `CUC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid,
      "response dropped while stalled")
   `CUC_ASSERT(a_read_pos, clock, reset,
      rsp_valid && result_kind == cuc_pkg::KIND_COUNT |-> position == '0,
      "count read with nonzero position")
   `CUC_ASSERT(a_end_fields, clock, reset,
      rsp_valid && result_kind == cuc_pkg::KIND_END |->
         (codon_index == '0 || codon_index == cuc_pkg::NO_CODON) &&
         amino_index == '0 && count_value == '0,
      "malformed end report")
   `CUC_ASSERT(a_unrec_flag, clock, reset,
      rsp_valid && result_kind == cuc_pkg::KIND_CODON && codon_index == cuc_pkg::NO_CODON
         |-> !all_recognized && count_value == '0,
      "unrecognized codon kept the flag set")

endmodule

bind codon_usage_counter cuc_checker u_cuc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .result_kind    (rsp_ch.result_kind),
   .codon_index    (rsp_ch.codon_index),
   .amino_index    (rsp_ch.amino_index),
   .position       (rsp_ch.position),
   .count_value    (rsp_ch.count_value),
   .all_recognized (rsp_ch.all_recognized)
);

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the codon usage counter, with its scoreboard class.
`timescale 1ns / 1ps

typedef struct packed {
   cuc_pkg::kind_type                  kind;
   logic [cuc_pkg::CODON_BITS-1:0]     codon_index;
   logic [cuc_pkg::AMINO_BITS-1:0]     amino_index;
   logic [cuc_pkg::FIELD_BITS-1:0]     position;
   logic [cuc_pkg::FIELD_BITS-1:0]     count_value;
   logic                               all_recognized;
} usage_report_type;

class usage_scoreboard;
   logic [cuc_pkg::COUNT_BITS-1:0] codon_tally [cuc_pkg::NUM_CODONS];
   logic [cuc_pkg::COUNT_BITS-1:0] amino_tally [cuc_pkg::NUM_AMINOS];
   logic [cuc_pkg::CODON_BITS-1:0] codon_of_triplet [cuc_pkg::NUM_CODONS];
   logic [cuc_pkg::AMINO_BITS-1:0] amino_of_codon [cuc_pkg::NUM_CODONS];
   logic [15:0]                    held_bases;
   int                             held_count;
   logic [cuc_pkg::FIELD_BITS-1:0] codon_pos;
   logic                           all_good;
   usage_report_type               expected_reports [$];
   int                             mismatch_count;

   // The lookup tables are rebuilt from the codon order written out as text, so that
   // the expected indexes do not lean on the tables of the design.
   function new();
      string order;
      string letters;
      string alphabet;
      int    code;
      order = {"GCAGCCGCGGCTTGCTGTGACGATGAAGAGTTCTTTGGAGGCGGGGGT",
               "CACCATATAATCATTAAAAAGCTACTCCTGCTTTTATTGATGAACAAT",
               "CCACCCCCGCCTCAACAGAGAAGGCGACGCCGGCGTTCATCCTCGTCT",
               "ACAACCACGACTGTAGTCGTGGTTTGGTACTATAGCAGTTAATAGTGA"};
      letters = "AAAACCDDEEFFGGGGHHIIIKKLLLLLLMNNPPPPQQRRRRRRSSSSTTTTVVVVWYYZZXXX";
      alphabet = "ACDEFGHIKLMNPQRSTVWYZX";
      for (int i = 0; i < cuc_pkg::NUM_CODONS; i++) begin
         code = base_value(order[3*i]) * 16 + base_value(order[3*i+1]) * 4
                + base_value(order[3*i+2]);
         codon_of_triplet[code] = cuc_pkg::CODON_BITS'(i);
         for (int a = 0; a < cuc_pkg::NUM_AMINOS; a++) begin
            if (alphabet[a] == letters[i]) begin
               amino_of_codon[i] = cuc_pkg::AMINO_BITS'(a);
            end
         end
      end
      clear_tallies();
      restart();
      mismatch_count = 0;
   endfunction

   function int base_value(input logic [cuc_pkg::CHAR_BITS-1:0] ch);
      case (ch)
         "A":     return 0;
         "C":     return 1;
         "G":     return 2;
         "T":     return 3;
         default: return -1;
      endcase
   endfunction

   function void clear_tallies();
      foreach (codon_tally[i]) codon_tally[i] = '0;
      foreach (amino_tally[i]) amino_tally[i] = '0;
   endfunction

   function void restart();
      held_bases = '0;
      held_count = 0;
      codon_pos = '0;
      all_good = 1'b1;
   endfunction

   function logic [cuc_pkg::FIELD_BITS-1:0] as_field(input logic [cuc_pkg::COUNT_BITS-1:0] v);
      return (v > cuc_pkg::FIELD_MAX) ? cuc_pkg::FIELD_MAX : cuc_pkg::FIELD_BITS'(v);
   endfunction

   function int outstanding();
      return expected_reports.size();
   endfunction

   function void add_expected(input usage_report_type r);
      expected_reports.insert(expected_reports.size(), r);
   endfunction

   function void note_request(input logic [cuc_pkg::CMD_BITS-1:0] cmd,
                              input logic [cuc_pkg::CHAR_BITS-1:0] ch,
                              input logic [cuc_pkg::INDEX_BITS-1:0] idx);
      usage_report_type              r;
      logic [cuc_pkg::CHAR_BITS-1:0] up;
      int                            b0;
      int                            b1;
      int                            b2;
      up = (ch >= "a" && ch <= "z") ? ch - 8'h20 : ch;
      r = '0;
      r.codon_index = cuc_pkg::NO_CODON;
      case (cmd)
         cuc_pkg::CMD_CLEAR: begin
            clear_tallies();
            restart();
         end
         cuc_pkg::CMD_BASE: begin
            if (held_count < 2) begin
               held_bases = {held_bases[7:0], up};
               held_count++;
            end else begin
               b0 = base_value(held_bases[15:8]);
               b1 = base_value(held_bases[7:0]);
               b2 = base_value(up);
               r.kind = cuc_pkg::KIND_CODON;
               if (b0 >= 0 && b1 >= 0 && b2 >= 0) begin
                  r.codon_index = codon_of_triplet[b0 * 16 + b1 * 4 + b2];
                  r.amino_index = amino_of_codon[r.codon_index];
                  if (codon_tally[r.codon_index] != cuc_pkg::COUNT_MAX) begin
                     codon_tally[r.codon_index] += 1'b1;
                  end
                  if (amino_tally[r.amino_index] != cuc_pkg::COUNT_MAX) begin
                     amino_tally[r.amino_index] += 1'b1;
                  end
               end else begin
                  all_good = 1'b0;
               end
               r.position = codon_pos;
               if (codon_pos != cuc_pkg::FIELD_MAX) begin
                  codon_pos += 1'b1;
               end
               held_bases = '0;
               held_count = 0;
               r.all_recognized = all_good;
               add_expected(r);
            end
         end
         cuc_pkg::CMD_READ_CODON: begin
            r.kind = cuc_pkg::KIND_COUNT;
            r.codon_index = cuc_pkg::CODON_BITS'(idx);
            r.amino_index = amino_of_codon[idx];
            r.count_value = as_field(codon_tally[idx]);
            r.all_recognized = all_good;
            add_expected(r);
         end
         cuc_pkg::CMD_READ_AMINO: begin
            r.kind = cuc_pkg::KIND_COUNT;
            if (idx < cuc_pkg::NUM_AMINOS) begin
               r.amino_index = cuc_pkg::AMINO_BITS'(idx);
               r.count_value = as_field(amino_tally[idx]);
            end
            r.all_recognized = all_good;
            add_expected(r);
         end
         cuc_pkg::CMD_END: begin
            r.kind = cuc_pkg::KIND_END;
            // A partial codon left over counts as one that was not recognized.
            if (held_count != 0) begin
               all_good = 1'b0;
            end else begin
               r.codon_index = '0;
            end
            r.position = codon_pos;
            r.all_recognized = all_good;
            add_expected(r);
            restart();
         end
         default: begin
         end
      endcase
   endfunction

   function void compare_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   function void check_response(input usage_report_type got);
      usage_report_type want;
      if (expected_reports.size() == 0) begin
         $error("result with nothing expected: kind %0d, codon_index %0d",
                got.kind, got.codon_index);
         mismatch_count++;
         return;
      end
      want = expected_reports.pop_front();
      compare_field("result_kind", want.kind, got.kind);
      compare_field("codon_index", want.codon_index, got.codon_index);
      compare_field("amino_index", want.amino_index, got.amino_index);
      compare_field("position", want.position, got.position);
      compare_field("count_value", want.count_value, got.count_value);
      compare_field("all_recognized", want.all_recognized, got.all_recognized);
   endfunction
endclass

module testbench;
   localparam int CLOCK_PERIOD   = 8;
   localparam int RANDOM_ITEMS   = 1300;
   localparam int HOLD_OFF_LEN   = 64;
   localparam int SETTLE_CYCLES  = 16;
   localparam int TIMEOUT_CYCLES = 250000;

   localparam logic [cuc_pkg::CMD_BITS-1:0] CMD_SPARE_FIRST = cuc_pkg::CMD_END + 1'b1;
   localparam logic [cuc_pkg::CMD_BITS-1:0] CMD_SPARE_LAST  = '1;

   logic clock = 1'b0;
   logic reset;

   cuc_req_if req_bus ();
   cuc_rsp_if rsp_bus ();

   codon_usage_counter dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   usage_scoreboard  tracker = new();
   usage_report_type observed;

   bit hold_off_request = 1'b0;
   int hold_left = 0;
   int span_left = 0;
   int stall_mode = 0;
   int burst_left = 0;
   int random_sent = 0;
   bit hold_done = 1'b0;
   bit drain_done = 1'b0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Both channels are watched at the rising edge, before the design updates.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            tracker.note_request(req_bus.command, req_bus.char_in, req_bus.table_index);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            observed.kind = cuc_pkg::kind_type'(rsp_bus.result_kind);
            observed.codon_index = rsp_bus.codon_index;
            observed.amino_index = rsp_bus.amino_index;
            observed.position = rsp_bus.position;
            observed.count_value = rsp_bus.count_value;
            observed.all_recognized = rsp_bus.all_recognized;
            tracker.check_response(observed);
         end
      end
   end

   // Response side: stretches of steady, mostly ready, sparse or toggling readiness, plus one long
   // hold-off when the stimulus asks for it.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = HOLD_OFF_LEN;
         end
         if (span_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            span_left = $urandom_range(10, 150);
         end
         span_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (stall_mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= ($urandom_range(0, 99) < 75);
               2:       rsp_bus.ready <= ($urandom_range(0, 99) < 25);
               default: rsp_bus.ready <= ~rsp_bus.ready;
            endcase
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_item(input logic [cuc_pkg::CMD_BITS-1:0] cmd,
                            input logic [cuc_pkg::CHAR_BITS-1:0] ch,
                            input logic [cuc_pkg::INDEX_BITS-1:0] idx);
      req_bus.valid <= 1'b1;
      req_bus.command <= cmd;
      req_bus.char_in <= ch;
      req_bus.table_index <= idx;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_chars(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_item(cuc_pkg::CMD_BASE, s[i], cuc_pkg::INDEX_BITS'($urandom_range(0, 63)));
      end
   endtask

   task automatic pace();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic wait_drained();
      while (tracker.outstanding() != 0) @(negedge clock);
   endtask

   task automatic send_random_item();
      string                          nucleotides;
      int                             pick;
      logic [cuc_pkg::CHAR_BITS-1:0]  ch;
      logic [cuc_pkg::INDEX_BITS-1:0] idx;
      nucleotides = "ACGTacgt";
      pick = $urandom_range(0, 99);
      ch = cuc_pkg::CHAR_BITS'($urandom_range(0, 255));
      idx = cuc_pkg::INDEX_BITS'($urandom_range(0, 63));
      if (pick < 64) begin
         if ($urandom_range(0, 19) != 0) begin
            ch = nucleotides[$urandom_range(0, 7)];
         end
         send_item(cuc_pkg::CMD_BASE, ch, idx);
      end else if (pick < 80) begin
         send_item(cuc_pkg::CMD_READ_CODON, ch, idx);
      end else if (pick < 90) begin
         if ($urandom_range(0, 1) != 0) begin
            idx = cuc_pkg::INDEX_BITS'($urandom_range(0, cuc_pkg::NUM_AMINOS - 1));
         end
         send_item(cuc_pkg::CMD_READ_AMINO, ch, idx);
      end else if (pick < 96) begin
         send_item(cuc_pkg::CMD_END, ch, idx);
      end else if (pick < 98) begin
         send_item(cuc_pkg::CMD_CLEAR, ch, idx);
      end else begin
         // Unused commands are dropped by the block and do not count as stimulus.
         send_item(cuc_pkg::CMD_BITS'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                   ch, idx);
         return;
      end
      random_sent++;
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.command = cuc_pkg::CMD_CLEAR;
      req_bus.char_in = '0;
      req_bus.table_index = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: empty reads, lower case, the split serine, bad characters,
      // ends with and without a partial codon, unused commands and clear.
      send_item(cuc_pkg::CMD_READ_CODON, 8'h00, 6'd0);
      send_item(cuc_pkg::CMD_READ_AMINO, 8'hFF, 6'd63);
      send_chars("atg");
      send_chars("agT");
      send_chars("Nt");
      send_item(cuc_pkg::CMD_BASE, 8'hFF, 6'd63);
      send_item(cuc_pkg::CMD_READ_CODON, 8'h00, 6'd29);
      send_item(cuc_pkg::CMD_READ_AMINO, 8'h00, 6'd20);
      send_item(cuc_pkg::CMD_BASE, 8'h00, 6'd0);
      send_item(cuc_pkg::CMD_END, 8'h00, 6'd0);
      send_item(CMD_SPARE_FIRST, 8'hFF, 6'd63);
      send_item(CMD_SPARE_LAST, 8'h00, 6'd0);
      send_chars("GGG");
      send_item(cuc_pkg::CMD_END, 8'hFF, 6'd63);
      send_item(cuc_pkg::CMD_CLEAR, 8'hFF, 6'd63);
      send_item(cuc_pkg::CMD_READ_CODON, 8'hFF, 6'd29);
      send_item(cuc_pkg::CMD_READ_AMINO, 8'hFF, 6'd21);

      while (random_sent < RANDOM_ITEMS) begin
         if (!hold_done && random_sent >= 400) begin
            // Keep offering while the response side holds off, so the queue fills.
            hold_done = 1'b1;
            hold_off_request = 1'b1;
            repeat (24) send_random_item();
         end else if (!drain_done && random_sent >= 850) begin
            drain_done = 1'b1;
            req_bus.valid <= 1'b0;
            wait_drained();
         end else begin
            pace();
            send_random_item();
         end
      end
      req_bus.valid <= 1'b0;

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (tracker.mismatch_count == 0 && tracker.outstanding() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("FAIL");
      $finish;
   end
endmodule
